>>> src/set_assoc_lru_cache_tags_unit_assert.svh
// Assertion macros for the cache tag unit's RTL, included by set_assoc_lru_cache_tags_unit.
// No dependencies; the macros compile to nothing when SYNTH is defined.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_UNIT_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SALC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
`define SALC_ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define SALC_ASSERT(name, clk, rst_n, prop)
`define SALC_ASSERT_NEVER(name, clk, rst_n, expr)
`endif
`endif

>>> src/salc_pkg.sv
// Shared constants, types and register codes of the cache tag unit.
// No dependencies; every other file of the unit but the assert header refers to this package.
package salc_pkg;

  localparam int unsigned AddrW     = 32;
  localparam int unsigned TagW      = 32;
  localparam int unsigned BoW       = 4;
  localparam int unsigned SibW      = 3;
  localparam int unsigned WiuW      = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 4;
  // Widest set field the set_index_bits register can select.
  localparam int unsigned SetFieldW = (1 << SibW) - 1;

  localparam int unsigned DefaultSets = 64;
  localparam int unsigned DefaultWays = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_OFFSET = 2'd0,
    CFG_SET_INDEX    = 2'd1,
    CFG_WAYS_IN_USE  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_WRITE = 1'b1
  } access_kind_e;

  typedef struct packed {
    logic [BoW-1:0]  block_offset_bits;
    logic [SibW-1:0] set_index_bits;
    logic [WiuW-1:0] ways_in_use;
  } salc_cfg_t;

  localparam salc_cfg_t CfgReset = '{
    block_offset_bits: 4'd6,
    set_index_bits:    3'd6,
    ways_in_use:       4'd8
  };

  typedef struct packed {
    logic            hit;
    logic            evicted_valid;
    logic [TagW-1:0] evicted_tag;
    logic            evicted_dirty;
  } salc_rsp_t;

endpackage

>>> src/salc_if.sv
// Handshake channels of the cache tag unit: access items, result items, register writes.
// Depends on salc_pkg for the field widths.
interface salc_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [salc_pkg::AddrW-1:0]   address;

  modport source (output valid, output kind, output address, input ready);
  modport sink (input valid, input kind, input address, output ready);
endinterface

interface salc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         evicted_valid;
  logic [salc_pkg::TagW-1:0]    evicted_tag;
  logic                         evicted_dirty;

  modport source (output valid, output hit, output evicted_valid, output evicted_tag,
                  output evicted_dirty, input ready);
  modport sink (input valid, input hit, input evicted_valid, input evicted_tag,
                input evicted_dirty, output ready);
endinterface

interface salc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [salc_pkg::CfgIdxW-1:0]  index;
  logic [salc_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/set_assoc_lru_cache_tags_unit.sv
// Tag store of a set-associative cache with true LRU replacement and dirty marks. Each
// access item (read or write, byte address) gives one result item: hit, and for a write
// miss in a full set the tag and dirty mark of the evicted least recent line. The idle state
// takes an item and reads its set from the tag and line state memories; the lookup state
// compares, updates the LRU ranks and writes the set back. The next item is taken only back
// in the idle state, so no new item is taken before the last one is written back, and the
// lookup state holds an item while the previous result still waits. After reset a
// clearing pass over every set resets the line state memory, during which no
// access item is taken; register writes are taken at any time and must only be issued
// while no access is in flight.
// Depends on salc_pkg, salc_if, salc_tag_mem, salc_meta_mem, salc_update and the assert header.
`include "set_assoc_lru_cache_tags_unit_assert.svh"

module set_assoc_lru_cache_tags_unit #(
  parameter int unsigned SETS = salc_pkg::DefaultSets,
  parameter int unsigned WAYS = salc_pkg::DefaultWays
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  salc_req_if.sink   req_i,
  salc_rsp_if.source rsp_o,
  salc_cfg_if.sink   cfg_i
);

  localparam int unsigned SetW      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WayW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AgeW      = WayW;
  localparam int unsigned SfW       = salc_pkg::SetFieldW;
  localparam int unsigned SetFieldN = 1 << SfW;
  localparam int unsigned ShW       = salc_pkg::BoW + 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [SetW-1:0]            clr_row_q, clr_row_d;
  salc_pkg::salc_cfg_t        cfg_q;

  logic                       kind_q;
  logic [salc_pkg::TagW-1:0]  tag_q;
  logic [SetW-1:0]            row_q;

  logic                       rsp_valid_q;
  salc_pkg::salc_rsp_t        rsp_q;

  logic                       acc;
  logic                       look_done;
  logic [salc_pkg::AddrW-1:0] shifted;
  logic [SfW-1:0]             set_mask;
  logic [SfW-1:0]             set_field;
  logic [ShW-1:0]             tag_shamt;
  logic [salc_pkg::TagW-1:0]  tag_in;
  logic [SetW-1:0]            set_mod [SetFieldN];
  logic [SetW-1:0]            set_row;

  logic [WAYS-1:0][salc_pkg::TagW-1:0] rd_tags;
  logic [WAYS-1:0]            rd_valid;
  logic [WAYS-1:0]            rd_dirty;
  logic [WAYS-1:0][AgeW-1:0]  rd_age;

  salc_pkg::salc_rsp_t        upd_rsp;
  logic                       upd_meta_we;
  logic                       upd_tag_we;
  logic [WayW-1:0]            upd_way;
  logic [WAYS-1:0]            upd_valid;
  logic [WAYS-1:0]            upd_dirty;
  logic [WAYS-1:0][AgeW-1:0]  upd_age;

  logic                       clearing;
  logic                       meta_we;
  logic [SetW-1:0]            meta_row;
  logic [WAYS-1:0]            meta_valid;
  logic [WAYS-1:0]            meta_dirty;
  logic [WAYS-1:0][AgeW-1:0]  meta_age;

  // Register writes.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= salc_pkg::CfgReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (salc_pkg::cfg_reg_e'(cfg_i.index))
        salc_pkg::CFG_BLOCK_OFFSET: begin
          cfg_q.block_offset_bits <= cfg_i.data[salc_pkg::BoW-1:0];
        end
        salc_pkg::CFG_SET_INDEX: begin
          cfg_q.set_index_bits <= cfg_i.data[salc_pkg::SibW-1:0];
        end
        salc_pkg::CFG_WAYS_IN_USE: begin
          cfg_q.ways_in_use <= cfg_i.data[salc_pkg::WiuW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Address split. The set field wraps modulo SETS through a constant table.
  assign shifted   = req_i.address >> cfg_q.block_offset_bits;
  assign set_mask  = SfW'((8'd1 << cfg_q.set_index_bits) - 8'd1);
  assign set_field = shifted[SfW-1:0] & set_mask;
  assign tag_shamt = {1'b0, cfg_q.block_offset_bits} + ShW'(cfg_q.set_index_bits);
  assign tag_in    = salc_pkg::TagW'(req_i.address >> tag_shamt);

  for (genvar gi = 0; gi < SetFieldN; gi++) begin : g_set_mod
    assign set_mod[gi] = SetW'(gi % SETS);
  end

  assign set_row = set_mod[set_field];

  // Control. A set is read only in the idle state and written only in the lookup state or
  // by the clearing pass, so a read never overlaps a write of the same set.
  assign clearing    = (state_q == ST_CLEAR);
  assign req_i.ready = (state_q == ST_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign look_done   = (state_q == ST_LOOK) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d   = state_q;
    clr_row_d = clr_row_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_row_q == SetW'(SETS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_row_d = clr_row_q + SetW'(1);
        end
      end
      ST_IDLE: begin
        if (acc) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (look_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_row_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_row_q <= clr_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      kind_q <= req_i.kind;
      tag_q  <= tag_in;
      row_q  <= set_row;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (look_done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (look_done) begin
      rsp_q <= upd_rsp;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.hit           = rsp_q.hit;
  assign rsp_o.evicted_valid = rsp_q.evicted_valid;
  assign rsp_o.evicted_tag   = rsp_q.evicted_tag;
  assign rsp_o.evicted_dirty = rsp_q.evicted_dirty;

  // Memories and set update.
  assign meta_we    = clearing || (look_done && upd_meta_we);
  assign meta_row   = clearing ? clr_row_q : row_q;
  assign meta_valid = clearing ? '0 : upd_valid;
  assign meta_dirty = clearing ? '0 : upd_dirty;
  assign meta_age   = clearing ? '0 : upd_age;

  salc_tag_mem #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_tag_mem (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_row_i  (set_row),
    .rd_tags_o (rd_tags),
    .wr_en_i   (look_done && upd_tag_we),
    .wr_row_i  (row_q),
    .wr_way_i  (upd_way),
    .wr_tag_i  (tag_q)
  );

  salc_meta_mem #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_meta_mem (
    .clk_i      (clk_i),
    .rd_en_i    (acc),
    .rd_row_i   (set_row),
    .rd_valid_o (rd_valid),
    .rd_dirty_o (rd_dirty),
    .rd_age_o   (rd_age),
    .wr_en_i    (meta_we),
    .wr_row_i   (meta_row),
    .wr_valid_i (meta_valid),
    .wr_dirty_i (meta_dirty),
    .wr_age_i   (meta_age)
  );

  salc_update #(
    .WAYS (WAYS)
  ) u_update (
    .kind_i        (kind_q),
    .tag_i         (tag_q),
    .ways_in_use_i (cfg_q.ways_in_use),
    .row_tag_i     (rd_tags),
    .row_valid_i   (rd_valid),
    .row_dirty_i   (rd_dirty),
    .row_age_i     (rd_age),
    .rsp_o         (upd_rsp),
    .meta_we_o     (upd_meta_we),
    .tag_we_o      (upd_tag_we),
    .way_o         (upd_way),
    .new_valid_o   (upd_valid),
    .new_dirty_o   (upd_dirty),
    .new_age_o     (upd_age)
  );

  `SALC_ASSERT(a_accept_to_lookup, clk_i, rst_ni, acc |=> state_q == ST_LOOK)
  `SALC_ASSERT(a_result_after_lookup, clk_i, rst_ni,
               $rose(rsp_valid_q) |-> $past(state_q) == ST_LOOK)
  `SALC_ASSERT(a_evict_on_write_miss, clk_i, rst_ni,
               (look_done && upd_rsp.evicted_valid) |->
               (kind_q == salc_pkg::KIND_WRITE && !upd_rsp.hit))
  `SALC_ASSERT_NEVER(a_written_way_invalid, clk_i, rst_ni,
                     look_done && upd_meta_we && !upd_valid[upd_way])

endmodule

>>> src/salc_tag_mem.sv
// Tag memory: one row per set holding the tag of every way, with a registered read.
// Depends on salc_pkg for the tag width.
module salc_tag_mem #(
  parameter  int unsigned SETS = salc_pkg::DefaultSets,
  parameter  int unsigned WAYS = salc_pkg::DefaultWays,
  localparam int unsigned SetW = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                                   clk_i,
  input  logic                                   rd_en_i,
  input  logic [SetW-1:0]                        rd_row_i,
  output logic [WAYS-1:0][salc_pkg::TagW-1:0]    rd_tags_o,
  input  logic                                   wr_en_i,
  input  logic [SetW-1:0]                        wr_row_i,
  input  logic [WayW-1:0]                        wr_way_i,
  input  logic [salc_pkg::TagW-1:0]              wr_tag_i
);

  logic [salc_pkg::TagW-1:0]              mem [SETS][WAYS];
  logic [WAYS-1:0][salc_pkg::TagW-1:0]    rd_tags_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i][wr_way_i] <= wr_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      for (int w = 0; w < WAYS; w++) begin
        rd_tags_q[w] <= mem[rd_row_i][w];
      end
    end
  end

  assign rd_tags_o = rd_tags_q;

endmodule

>>> src/salc_meta_mem.sv
// Line state memory: valid, dirty and LRU rank of every way, one row per set.
// Depends on salc_pkg only through the parameter defaults.
module salc_meta_mem #(
  parameter  int unsigned SETS = salc_pkg::DefaultSets,
  parameter  int unsigned WAYS = salc_pkg::DefaultWays,
  localparam int unsigned SetW = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int unsigned AgeW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [SetW-1:0]            rd_row_i,
  output logic [WAYS-1:0]            rd_valid_o,
  output logic [WAYS-1:0]            rd_dirty_o,
  output logic [WAYS-1:0][AgeW-1:0]  rd_age_o,
  input  logic                       wr_en_i,
  input  logic [SetW-1:0]            wr_row_i,
  input  logic [WAYS-1:0]            wr_valid_i,
  input  logic [WAYS-1:0]            wr_dirty_i,
  input  logic [WAYS-1:0][AgeW-1:0]  wr_age_i
);

  localparam int unsigned RowW = WAYS * (AgeW + 2);

  logic [RowW-1:0] mem [SETS];
  logic [RowW-1:0] rd_row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= {wr_age_i, wr_dirty_i, wr_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= mem[rd_row_i];
    end
  end

  assign {rd_age_o, rd_dirty_o, rd_valid_o} = rd_row_q;

endmodule

>>> src/salc_update.sv
// Lookup and LRU update of one set: finds hit, victim or free way and builds the new row.
// Depends on salc_pkg for the result struct, field widths and access kinds.
module salc_update #(
  parameter  int unsigned WAYS = salc_pkg::DefaultWays,
  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int unsigned AgeW = WayW
) (
  input  logic                                kind_i,
  input  logic [salc_pkg::TagW-1:0]           tag_i,
  input  logic [salc_pkg::WiuW-1:0]           ways_in_use_i,
  input  logic [WAYS-1:0][salc_pkg::TagW-1:0] row_tag_i,
  input  logic [WAYS-1:0]                     row_valid_i,
  input  logic [WAYS-1:0]                     row_dirty_i,
  input  logic [WAYS-1:0][AgeW-1:0]           row_age_i,
  output salc_pkg::salc_rsp_t                 rsp_o,
  output logic                                meta_we_o,
  output logic                                tag_we_o,
  output logic [WayW-1:0]                     way_o,
  output logic [WAYS-1:0]                     new_valid_o,
  output logic [WAYS-1:0]                     new_dirty_o,
  output logic [WAYS-1:0][AgeW-1:0]           new_age_o
);

  localparam int unsigned CntW = $clog2(WAYS + 1);
  localparam int unsigned EffW = salc_pkg::WiuW + 1;
  localparam int unsigned CmpW = (CntW > EffW) ? CntW : EffW;

  logic [CntW-1:0] count;
  logic [EffW-1:0] eff_ways;
  logic [WAYS-1:0] match;
  logic [WAYS-1:0] oldest;
  logic [WayW-1:0] hit_way;
  logic [WayW-1:0] old_way;
  logic [WayW-1:0] free_way;
  logic            hit;
  logic            full;
  logic            evict;
  logic            insert;
  logic [CntW-1:0] thr;

  assign count = CntW'($countones(row_valid_i));

  always_comb begin
    if (ways_in_use_i == '0) begin
      eff_ways = EffW'(1);
    end else if ({1'b0, ways_in_use_i} > EffW'(WAYS)) begin
      eff_ways = EffW'(WAYS);
    end else begin
      eff_ways = {1'b0, ways_in_use_i};
    end
  end

  // Ranks of the valid lines in a set always form 0..count-1, so the least recent
  // line is the one whose rank equals count-1.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w]  = row_valid_i[w] && (row_tag_i[w] == tag_i);
      oldest[w] = row_valid_i[w] && (CntW'(row_age_i[w]) == count - CntW'(1));
    end
  end

  always_comb begin
    hit_way  = '0;
    old_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WayW'(w);
      end
      if (oldest[w]) begin
        old_way = WayW'(w);
      end
      if (!row_valid_i[w]) begin
        free_way = WayW'(w);
      end
    end
  end

  assign hit    = |match;
  assign full   = CmpW'(count) >= CmpW'(eff_ways);
  assign evict  = !hit && (kind_i == salc_pkg::KIND_WRITE) && full;
  assign insert = !hit && (kind_i == salc_pkg::KIND_WRITE) && !full;

  always_comb begin
    if (hit) begin
      way_o = hit_way;
    end else if (evict) begin
      way_o = old_way;
    end else begin
      way_o = free_way;
    end
  end

  // Filling a free way ages every valid line; a hit or an eviction ages only the
  // lines more recent than the chosen one.
  assign thr = insert ? count : CntW'(row_age_i[way_o]);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (WayW'(w) == way_o) begin
        new_valid_o[w] = 1'b1;
        new_age_o[w]   = '0;
        new_dirty_o[w] = hit ? (row_dirty_i[w] || (kind_i == salc_pkg::KIND_WRITE)) : 1'b1;
      end else begin
        new_valid_o[w] = row_valid_i[w];
        new_dirty_o[w] = row_dirty_i[w];
        if (row_valid_i[w] && (CntW'(row_age_i[w]) < thr)) begin
          new_age_o[w] = row_age_i[w] + AgeW'(1);
        end else begin
          new_age_o[w] = row_age_i[w];
        end
      end
    end
  end

  assign meta_we_o = hit || (kind_i == salc_pkg::KIND_WRITE);
  assign tag_we_o  = evict || insert;

  always_comb begin
    rsp_o.hit           = hit;
    rsp_o.evicted_valid = evict;
    rsp_o.evicted_tag   = evict ? row_tag_i[old_way] : '0;
    rsp_o.evicted_dirty = evict ? row_dirty_i[old_way] : 1'b0;
  end

endmodule

>>> tb/set_assoc_lru_cache_tags_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the set-associative LRU cache tag unit.
// Depends on salc_pkg, the salc_if channel interfaces and set_assoc_lru_cache_tags_unit.
module set_assoc_lru_cache_tags_unit_tb;

  localparam int unsigned SETS   = salc_pkg::DefaultSets;
  localparam int unsigned WAYS   = salc_pkg::DefaultWays;
  localparam int unsigned NLINES = SETS * WAYS;
  // Index past the end of the register list; the unit must ignore writes to it.
  localparam logic [salc_pkg::CfgIdxW-1:0] CFG_SPARE = 2'd3;

  // Shadow copy of the tag store that predicts the result of every accepted access.
  class lru_tag_tracker;
    int unsigned               offset_bits;
    int unsigned               index_bits;
    int unsigned               ways_cfg;
    int unsigned               mismatches;
    salc_pkg::salc_rsp_t       expected_rsp[$];
    logic [salc_pkg::TagW-1:0] tag_of[NLINES];
    bit                        valid_of[NLINES];
    bit                        dirty_of[NLINES];
    int unsigned               rank_of[NLINES];

    function new();
      offset_bits = salc_pkg::CfgReset.block_offset_bits;
      index_bits  = salc_pkg::CfgReset.set_index_bits;
      ways_cfg    = salc_pkg::CfgReset.ways_in_use;
      mismatches  = 0;
      foreach (valid_of[i]) begin
        tag_of[i]   = '0;
        valid_of[i] = 1'b0;
        dirty_of[i] = 1'b0;
        rank_of[i]  = 0;
      end
    endfunction

    function int unsigned pending();
      return expected_rsp.size();
    endfunction

    function int unsigned eff_ways();
      if (ways_cfg == 0) return 1;
      if (ways_cfg > WAYS) return WAYS;
      return ways_cfg;
    endfunction

    function void set_reg(logic [salc_pkg::CfgIdxW-1:0] idx,
                          logic [salc_pkg::CfgDataW-1:0] data);
      case (idx)
        salc_pkg::CFG_BLOCK_OFFSET: offset_bits = data;
        salc_pkg::CFG_SET_INDEX:    index_bits = data[salc_pkg::SibW-1:0];
        salc_pkg::CFG_WAYS_IN_USE:  ways_cfg = data;
        default: ;
      endcase
    endfunction

    // Every valid line of the set that was more recent than entry e ages by one.
    function void promote(int unsigned base, int unsigned e);
      int unsigned prior;
      prior = rank_of[e];
      for (int w = 0; w < WAYS; w++) begin
        if (base + w != e && valid_of[base + w] && rank_of[base + w] < prior)
          rank_of[base + w]++;
      end
      rank_of[e] = 0;
    endfunction

    function void note_access(salc_pkg::access_kind_e kind,
                              logic [salc_pkg::AddrW-1:0] addr);
      salc_pkg::salc_rsp_t       rsp;
      logic [31:0]               set_field;
      logic [salc_pkg::TagW-1:0] tag;
      int unsigned               base, count, hit_e, free_e, old_e, i;
      bit                        found, have_free, have_old;
      rsp       = '0;
      found     = 1'b0;
      have_free = 1'b0;
      have_old  = 1'b0;
      count     = 0;
      hit_e     = 0;
      free_e    = 0;
      old_e     = 0;
      set_field = (addr >> offset_bits) & ((32'd1 << index_bits) - 32'd1);
      base      = (set_field % SETS) * WAYS;
      tag       = addr >> (offset_bits + index_bits);
      for (int w = 0; w < WAYS; w++) begin
        i = base + w;
        if (valid_of[i]) begin
          count++;
          if (!found && tag_of[i] == tag) begin
            found = 1'b1;
            hit_e = i;
          end
          if (!have_old || rank_of[i] > rank_of[old_e]) begin
            have_old = 1'b1;
            old_e    = i;
          end
        end else if (!have_free) begin
          have_free = 1'b1;
          free_e    = i;
        end
      end
      if (found) begin
        promote(base, hit_e);
        if (kind == salc_pkg::KIND_WRITE) dirty_of[hit_e] = 1'b1;
        rsp.hit = 1'b1;
      end else if (kind == salc_pkg::KIND_WRITE) begin
        if (count >= eff_ways() && have_old) begin
          rsp.evicted_valid = 1'b1;
          rsp.evicted_tag   = tag_of[old_e];
          rsp.evicted_dirty = dirty_of[old_e];
          promote(base, old_e);
          tag_of[old_e]   = tag;
          dirty_of[old_e] = 1'b1;
        end else if (have_free) begin
          for (int w = 0; w < WAYS; w++) begin
            if (valid_of[base + w]) rank_of[base + w]++;
          end
          valid_of[free_e] = 1'b1;
          tag_of[free_e]   = tag;
          dirty_of[free_e] = 1'b1;
          rank_of[free_e]  = 0;
        end
      end
      expected_rsp.push_back(rsp);
    endfunction

    function void check_result(logic hit, logic ev_valid,
                               logic [salc_pkg::TagW-1:0] ev_tag, logic ev_dirty);
      salc_pkg::salc_rsp_t want;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: hit=%b evicted=%b tag=%h dirty=%b",
                   hit, ev_valid, ev_tag, ev_dirty);
        return;
      end
      want = expected_rsp.pop_front();
      if (hit !== want.hit || ev_valid !== want.evicted_valid ||
          ev_tag !== want.evicted_tag || ev_dirty !== want.evicted_dirty) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch at %0t: expected hit=%b evicted=%b tag=%h dirty=%b, %s",
                   $realtime, want.hit, want.evicted_valid, want.evicted_tag,
                   want.evicted_dirty,
                   $sformatf("got hit=%b evicted=%b tag=%h dirty=%b",
                             hit, ev_valid, ev_tag, ev_dirty));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  salc_req_if req_if ();
  salc_rsp_if rsp_if ();
  salc_cfg_if cfg_if ();

  lru_tag_tracker tracker = new();

  set_assoc_lru_cache_tags_unit #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      tracker.check_result(rsp_if.hit, rsp_if.evicted_valid, rsp_if.evicted_tag,
                           rsp_if.evicted_dirty);
  end

  // Result side: runs of ready broken by stalls, mostly short and now and then long.
  initial begin : rsp_ready_gen
    int unsigned run, stall;
    rsp_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      rsp_if.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      rsp_if.ready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
  end

  // Called just after the clock rises; leaves valid high after the item is taken.
  task automatic send_access(salc_pkg::access_kind_e kind,
                             logic [salc_pkg::AddrW-1:0] addr, int unsigned gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.kind    <= kind;
    req_if.address <= addr;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    tracker.note_access(kind, addr);
  endtask

  task automatic wait_quiet();
    req_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [salc_pkg::CfgIdxW-1:0] idx,
                           logic [salc_pkg::CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    tracker.set_reg(idx, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly accesses to a few hot sets with a small pool of tags, so that hits, fills and
  // evictions all happen often; others use any set with a pool tag, or are fully random.
  task automatic run_phase(logic [3:0] bo, logic [3:0] sib, logic [3:0] ways,
                           int unsigned count);
    int unsigned            nsets, pool, set_no, gap, pick, hold_at, ob, ib;
    logic [31:0]            salt, tag, addr;
    salc_pkg::access_kind_e kind;
    bit                     burst;
    wait_quiet();
    write_reg(salc_pkg::CFG_BLOCK_OFFSET, bo);
    write_reg(salc_pkg::CFG_SET_INDEX, sib);
    write_reg(salc_pkg::CFG_WAYS_IN_USE, ways);
    ob      = tracker.offset_bits;
    ib      = tracker.index_bits;
    nsets   = 1 << ib;
    pool    = tracker.eff_ways() + 3;
    salt    = $urandom;
    burst   = 1'b0;
    hold_at = $urandom_range(count / 4, count * 3 / 4);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      // Let the unit drain completely once per phase before going on.
      if (n == hold_at) wait_quiet();
      pick = $urandom_range(0, 99);
      gap  = burst ? 0 : (pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 3)
                                                        : $urandom_range(8, 30);
      kind = salc_pkg::access_kind_e'($urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) begin
        addr = $urandom;
      end else begin
        if ($urandom_range(0, 3) == 0)
          set_no = $urandom_range(0, nsets - 1);
        else
          set_no = ($urandom_range(0, 3) | ($urandom_range(0, 1) << 6)) & (nsets - 1);
        tag  = salt + $urandom_range(0, pool);
        addr = (tag << (ob + ib)) | (32'(set_no) << ob) | ($urandom & ((32'd1 << ob) - 1));
      end
      send_access(kind, addr, gap);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.kind    = salc_pkg::KIND_READ;
    req_if.address = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = salc_pkg::CFG_BLOCK_OFFSET;
    cfg_if.data    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed accesses with the reset settings: 64-byte lines, 64 sets, 8 ways.
    send_access(salc_pkg::KIND_READ, 32'h0000_0000, 0);
    send_access(salc_pkg::KIND_WRITE, 32'hFFFF_FFFF, 1);
    send_access(salc_pkg::KIND_READ, 32'hFFFF_FFC0, 0);
    send_access(salc_pkg::KIND_WRITE, 32'hFFFF_FFFF, 0);
    // Nine distinct tags in set 0: eight fill the set, the ninth evicts the oldest.
    for (int t = 1; t <= 9; t++) send_access(salc_pkg::KIND_WRITE, 32'(t) << 12, t % 2);
    send_access(salc_pkg::KIND_READ, 32'h0000_1000, 0);
    send_access(salc_pkg::KIND_READ, 32'h0000_2000, 0);
    send_access(salc_pkg::KIND_WRITE, 32'h0000_A000, 0);
    send_access(salc_pkg::KIND_READ, 32'h8000_0000, 2);
    send_access(salc_pkg::KIND_WRITE, 32'h0000_003F, 0);
    send_access(salc_pkg::KIND_READ, 32'h0000_0FC0, 0);
    send_access(salc_pkg::KIND_WRITE, 32'h7FFF_F000, 0);

    run_phase(4'd6, 4'd6, 4'd8, 300);
    run_phase(4'd0, 4'd0, 4'd1, 150);
    run_phase(4'd12, 4'd3, 4'd4, 250);
    // Fewer ways than lines already held: sets stay fuller than the new limit.
    run_phase(4'd12, 4'd3, 4'd2, 200);
    wait_quiet();
    write_reg(CFG_SPARE, 4'hA);
    // Widest offset and a set field wider than the store, so set numbers wrap.
    run_phase(4'd15, 4'hF, 4'd15, 250);
    run_phase(4'd4, 4'd2, 4'd0, 200);
    run_phase(4'd2, 4'd5, 4'd8, 250);
    run_phase(4'd6, 4'd6, 4'd7, 250);

    wait_quiet();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
